[design/rhc_pkg.sv]
// rhc_pkg: shared types and constants for the rgb to hsv converter
// used by rhc_prep, rhc_div_cell, rhc_post and rgb_to_hsv_convert
// no dependencies
package rhc_pkg;

    // hue sector codes, picked by the channel that holds the max
    localparam logic [1:0] SECTOR_RED   = 2'd0;
    localparam logic [1:0] SECTOR_GREEN = 2'd1;
    localparam logic [1:0] SECTOR_BLUE  = 2'd2;

    // hue offsets in degrees
    localparam logic [8:0] HUE_OFS_RED   = 9'd0;
    localparam logic [8:0] HUE_OFS_GREEN = 9'd120;
    localparam logic [8:0] HUE_OFS_BLUE  = 9'd240;
    localparam logic [8:0] HUE_FULL_TURN = 9'd360;

    // number of quotient bits, one division cell per bit
    localparam int DIV_STEPS = 8;

    // one restoring division in flight: partial remainder, dividend bits
    // still to shift in (msb first), quotient so far, divisor
    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] low;
        logic [7:0] quo;
        logic [7:0] div;
    } rhc_lane_t;

    // everything one pixel carries down the chain
    typedef struct packed {
        rhc_lane_t  hue_lane;
        rhc_lane_t  sat_lane;
        logic [1:0] sector;
        logic       neg;
        logic       grey;
        logic       black;
        logic [7:0] value;
        logic       frame_end;
    } rhc_stage_t;

    // packed output beat fields
    typedef struct packed {
        logic [8:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
        logic       frame_end;
    } rhc_result_t;

endpackage

[design/rhc_prep.sv]
// rhc_prep: front stage, finds max, min, delta, hue sector and both dividends
// depends on rhc_pkg
module rhc_prep
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          red,
    input  logic [7:0]          green,
    input  logic [7:0]          blue,
    input  logic                frame_end,
    output logic                out_valid,
    input  logic                out_ready,
    output rhc_pkg::rhc_stage_t out_data
);

    logic                valid_reg;
    logic                valid_next;
    rhc_pkg::rhc_stage_t data_reg;
    rhc_pkg::rhc_stage_t data_next;
    logic                advance;

    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  delta;
    logic [7:0]  p_ch;
    logic [7:0]  q_ch;
    logic [7:0]  diff;
    logic [15:0] hue_num;
    logic [15:0] sat_num;

    // stage moves when empty or the next stage takes its beat
    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    // max, min and the sector, red wins ties over green, green over blue
    always_comb
    begin
        data_next = '0;
        mn = (red < green) ? red : green;
        mn = (mn < blue) ? mn : blue;
        if (red >= green && red >= blue)
        begin
            mx = red;
            data_next.sector = rhc_pkg::SECTOR_RED;
            p_ch = green;
            q_ch = blue;
        end
        else if (green >= blue)
        begin
            mx = green;
            data_next.sector = rhc_pkg::SECTOR_GREEN;
            p_ch = blue;
            q_ch = red;
        end
        else
        begin
            mx = blue;
            data_next.sector = rhc_pkg::SECTOR_BLUE;
            p_ch = red;
            q_ch = green;
        end
        delta = mx - mn;
        data_next.neg = (p_ch < q_ch);
        diff = data_next.neg ? (q_ch - p_ch) : (p_ch - q_ch);

        // 60*diff and 255*delta by shifts
        hue_num = {2'b00, diff, 6'b000000} - {6'b000000, diff, 2'b00};
        sat_num = {delta, 8'h00} - {8'h00, delta};

        // quotients stay below 256, so the top byte starts as the remainder
        data_next.hue_lane.rem = hue_num[15:8];
        data_next.hue_lane.low = hue_num[7:0];
        data_next.hue_lane.quo = '0;
        data_next.hue_lane.div = delta;
        data_next.sat_lane.rem = sat_num[15:8];
        data_next.sat_lane.low = sat_num[7:0];
        data_next.sat_lane.quo = '0;
        data_next.sat_lane.div = mx;

        data_next.grey      = (delta == 8'h00);
        data_next.black     = (mx == 8'h00);
        data_next.value     = mx;
        data_next.frame_end = frame_end;
    end

    // valid flag
    assign valid_next = advance ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[design/rhc_div_cell.sv]
// rhc_div_cell: one restoring division step for the hue and saturation lanes
// depends on rhc_pkg
module rhc_div_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rhc_pkg::rhc_stage_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rhc_pkg::rhc_stage_t out_data
);

    logic                valid_reg;
    logic                valid_next;
    rhc_pkg::rhc_stage_t data_reg;
    rhc_pkg::rhc_stage_t data_next;
    logic                advance;

    // shift in one dividend bit, subtract the divisor when it fits
    function automatic rhc_pkg::rhc_lane_t lane_step(input rhc_pkg::rhc_lane_t lane);
        rhc_pkg::rhc_lane_t res;
        logic [8:0]         trial;
        logic [8:0]         diff;
        logic               fits;
        res   = lane;
        trial = {lane.rem, lane.low[7]};
        diff  = trial - {1'b0, lane.div};
        fits  = (trial >= {1'b0, lane.div});
        res.rem = fits ? diff[7:0] : trial[7:0];
        res.low = {lane.low[6:0], 1'b0};
        res.quo = {lane.quo[6:0], fits};
        return res;
    endfunction

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    // both lanes step, the rest rides along
    always_comb
    begin
        data_next          = in_data;
        data_next.hue_lane = lane_step(in_data.hue_lane);
        data_next.sat_lane = lane_step(in_data.sat_lane);
    end

    assign valid_next = advance ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[design/rhc_post.sv]
// rhc_post: last stage, adds the sector offset to the hue quotient and
// applies the grey and black cases; holds the output register
// depends on rhc_pkg
module rhc_post
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rhc_pkg::rhc_stage_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rhc_pkg::rhc_result_t out_data
);

    logic                 valid_reg;
    logic                 valid_next;
    rhc_pkg::rhc_result_t data_reg;
    rhc_pkg::rhc_result_t data_next;
    logic                 advance;
    logic [8:0]           base;
    logic [8:0]           frac;
    logic [8:0]           frac_up;

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    // hue = offset + floor, or offset - ceil on a negative difference
    always_comb
    begin
        case (in_data.sector)
            rhc_pkg::SECTOR_RED:
            begin
                base = in_data.neg ? rhc_pkg::HUE_FULL_TURN : rhc_pkg::HUE_OFS_RED;
            end
            rhc_pkg::SECTOR_GREEN:
            begin
                base = rhc_pkg::HUE_OFS_GREEN;
            end
            rhc_pkg::SECTOR_BLUE:
            begin
                base = rhc_pkg::HUE_OFS_BLUE;
            end
            default:
            begin
                base = rhc_pkg::HUE_OFS_RED;
            end
        endcase
        frac    = {1'b0, in_data.hue_lane.quo};
        frac_up = frac + {8'h00, (in_data.hue_lane.rem != 8'h00)};

        data_next.hue        = in_data.grey ? 9'd0
                             : (in_data.neg ? (base - frac_up) : (base + frac));
        data_next.saturation = in_data.black ? 8'h00 : in_data.sat_lane.quo;
        data_next.brightness = in_data.value;
        data_next.frame_end  = in_data.frame_end;
    end

    assign valid_next = advance ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[design/rgb_to_hsv_convert.sv]
// rgb_to_hsv_convert: top level of the 8-bit rgb to hsv converter
// depends on rhc_pkg, rhc_prep, rhc_div_cell, rhc_post
//
// Usage:
// - s_axis carries one rgb pixel per beat, tlast marks the last pixel of a
//   frame; m_axis returns one hsv pixel per input beat, in order, tlast copied
// - hue is 0..359 whole degrees, saturation floor(255*delta/max), brightness
//   is the largest channel; grey pixels give hue 0, black pixels saturation 0
// - an accepted input beat reaches m_axis_tvalid through one front stage
//   (max, min, dividends), a chain of 8 division cells that each settle one
//   quotient bit of both divisions, and the output register
// - throughput is one pixel per cycle while m_axis_tready is high; the chain
//   of cells sets it, every cell handing its pixel on in each cycle
// - each stage has its own valid flag and takes a new beat when it is empty
//   or its successor takes its beat, so bubbles collapse and up to 10 pixels
//   sit in the block while m_axis_tready is low
// - when the receiver stalls the output beat holds; s_axis_tready drops once
//   every stage is full
// - reset clears all valid flags; no beat is lost across a stall
module rgb_to_hsv_convert
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic        s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // hue [8:0], saturation [16:9],
                                        // brightness [24:17], zero [31:25]
    output logic        m_axis_tlast    // frame_end_out
);

    localparam int NUM_CELLS = rhc_pkg::DIV_STEPS;

    // handshake and payload between the stages of the chain
    logic                chain_valid [NUM_CELLS + 1];
    logic                chain_ready [NUM_CELLS + 1];
    rhc_pkg::rhc_stage_t chain_data  [NUM_CELLS + 1];

    rhc_pkg::rhc_result_t result;

    // front stage
    rhc_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .red       (s_axis_tdata[7:0]),
        .green     (s_axis_tdata[15:8]),
        .blue      (s_axis_tdata[23:16]),
        .frame_end (s_axis_tlast),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    // division cells, one quotient bit each
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        rhc_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i + 1]),
            .out_ready (chain_ready[i + 1]),
            .out_data  (chain_data[i + 1])
        );
    end

    // offset, special cases and output register
    rhc_post u_post
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[NUM_CELLS]),
        .in_ready  (chain_ready[NUM_CELLS]),
        .in_data   (chain_data[NUM_CELLS]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (result)
    );

    // output beat packing
    assign m_axis_tdata = {7'b0000000, result.brightness, result.saturation, result.hue};
    assign m_axis_tlast = result.frame_end;

endmodule
